### rtl/gbpc_pkg.sv
// Shared types and constants for the grid broad-phase collision unit.
`default_nettype none

package gbpc_pkg;

    localparam int CMD_W      = 2;
    localparam int OBJ_PORT_W = 3;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int ORIGIN_W   = 16;
    localparam int SCALE_W    = 24;
    localparam int DIV_REG_W  = 4;
    localparam int FRAC_BITS  = 16;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SOLVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_STORE_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CELL_FULL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISIONS = 3'd4;

    typedef struct packed {
        logic take;
        logic clear_all;
        logic set_full;
        logic store_box;
        logic mul;
        logic clamp;
        logic cell_init;
        logic fill_rd;
        logic fill_upd;
        logic solve_init;
        logic sfill_rd;
        logic pair_init;
        logic mem_rd;
        logic box_rd;
        logic test;
        logic cell_next;
        logic scan_init;
        logic scan_step;
        logic emit_simple;
        logic emit_final;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic store_full;
        logic map_last;
        logic span_empty;
        logic span_last;
        logic fill_ge2;
        logic pair_last;
        logic cell_last;
        logic scan_last;
        logic scan_hold;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

### rtl/gbpc_ctrl.sv
// Controller state machine that sequences clear, add and solve transactions.
`default_nettype none

module gbpc_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire gbpc_pkg::dp_stat_t   stat,
    output gbpc_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_DECODE = 16'h0002,
        S_MUL    = 16'h0004,
        S_CLAMP  = 16'h0008,
        S_CINIT  = 16'h0010,
        S_FRD    = 16'h0020,
        S_FUPD   = 16'h0040,
        S_RESP   = 16'h0080,
        S_SFILL  = 16'h0100,
        S_SCHK   = 16'h0200,
        S_MRD    = 16'h0400,
        S_BRD    = 16'h0800,
        S_TEST   = 16'h1000,
        S_SINIT  = 16'h2000,
        S_SCAN   = 16'h4000,
        S_SEND   = 16'h8000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.cmd)
                    gbpc_pkg::CMD_CLEAR:
                    begin
                        cmd.clear_all = 1'b1;
                        state_next    = S_RESP;
                    end
                    gbpc_pkg::CMD_ADD:
                    begin
                        if (stat.store_full)
                        begin
                            cmd.set_full = 1'b1;
                            state_next   = S_RESP;
                        end
                        else
                        begin
                            cmd.store_box = 1'b1;
                            state_next    = S_MUL;
                        end
                    end
                    gbpc_pkg::CMD_SOLVE:
                    begin
                        cmd.solve_init = 1'b1;
                        state_next     = S_SFILL;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = stat.map_last ? S_CINIT : S_MUL;
            end
            S_CINIT:
            begin
                cmd.cell_init = 1'b1;
                state_next    = stat.span_empty ? S_RESP : S_FRD;
            end
            S_FRD:
            begin
                cmd.fill_rd = 1'b1;
                state_next  = S_FUPD;
            end
            S_FUPD:
            begin
                cmd.fill_upd = 1'b1;
                state_next   = stat.span_last ? S_RESP : S_FRD;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_simple = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SFILL:
            begin
                cmd.sfill_rd = 1'b1;
                state_next   = S_SCHK;
            end
            S_SCHK:
            begin
                if (stat.fill_ge2)
                begin
                    cmd.pair_init = 1'b1;
                    state_next    = S_MRD;
                end
                else
                begin
                    cmd.cell_next = 1'b1;
                    state_next    = stat.cell_last ? S_SINIT : S_SFILL;
                end
            end
            S_MRD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_BRD;
            end
            S_BRD:
            begin
                cmd.box_rd = 1'b1;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                cmd.test = 1'b1;
                if (stat.pair_last)
                begin
                    cmd.cell_next = 1'b1;
                    state_next    = stat.cell_last ? S_SINIT : S_SFILL;
                end
                else
                begin
                    state_next = S_MRD;
                end
            end
            S_SINIT:
            begin
                cmd.scan_init = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                if (!stat.scan_hold)
                begin
                    cmd.scan_step = 1'b1;
                    if (stat.scan_last)
                    begin
                        state_next = S_SEND;
                    end
                end
            end
            S_SEND:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/gbpc_dpath.sv
// Datapath: configuration, box store, cell tables, pair flags and result register.
`default_nettype none

module gbpc_dpath
#(
    parameter int MAX_OBJECTS = 8,
    parameter int GRID_DIV    = 8,
    parameter int CELL_SLOTS  = 8,
    parameter int COORD_BITS  = 16
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_write_en,
    input  wire logic [gbpc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [gbpc_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire logic [gbpc_pkg::CMD_W-1:0]             command,
    input  wire logic [COORD_BITS-1:0]                  box_min_x,
    input  wire logic [COORD_BITS-1:0]                  box_min_y,
    input  wire logic [COORD_BITS-1:0]                  box_max_x,
    input  wire logic [COORD_BITS-1:0]                  box_max_y,
    input  wire gbpc_pkg::ctrl_cmd_t                    cmd,
    output gbpc_pkg::dp_stat_t                          stat,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic                                        pair_valid,
    output logic [gbpc_pkg::OBJ_PORT_W-1:0]             first_object,
    output logic [gbpc_pkg::OBJ_PORT_W-1:0]             second_object,
    output logic                                        last,
    output logic [gbpc_pkg::STATUS_W-1:0]               status
);

    localparam int OBJ_W  = $clog2(MAX_OBJECTS);
    localparam int CNT_W  = $clog2(MAX_OBJECTS + 1);
    localparam int SLOT_W = $clog2(CELL_SLOTS);
    localparam int FILL_W = $clog2(CELL_SLOTS + 1);
    localparam int IDX_W  = $clog2(GRID_DIV + 1);
    localparam int CELLS  = GRID_DIV * GRID_DIV;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int MEM_D  = CELLS * (1 << SLOT_W);
    localparam int LIN_W  = 2 * IDX_W + 1;
    localparam int DW     = ((COORD_BITS > gbpc_pkg::ORIGIN_W) ? COORD_BITS
                            : gbpc_pkg::ORIGIN_W) + 1;
    localparam int PW     = DW - 1 + gbpc_pkg::SCALE_W;
    localparam int QW     = PW - gbpc_pkg::FRAC_BITS;
    localparam int BOX_W  = 4 * COORD_BITS;

    logic signed [gbpc_pkg::ORIGIN_W-1:0] origin_x_reg, origin_y_reg;
    logic [gbpc_pkg::SCALE_W-1:0]         scale_x_reg, scale_y_reg;
    logic [gbpc_pkg::DIV_REG_W-1:0]       div_reg;
    logic [IDX_W-1:0]                     div_eff;

    logic [gbpc_pkg::CMD_W-1:0]           cmd_reg;
    logic signed [COORD_BITS-1:0]         bx0_reg, by0_reg, bx1_reg, by1_reg;
    logic [CNT_W-1:0]                     count_reg;
    logic [OBJ_W-1:0]                     id_reg;
    logic [gbpc_pkg::STATUS_W-1:0]        st_reg;

    logic [1:0]                           k_reg;
    logic signed [COORD_BITS-1:0]         coord_sel;
    logic signed [gbpc_pkg::ORIGIN_W-1:0] org_sel;
    logic [gbpc_pkg::SCALE_W-1:0]         scale_sel;
    logic signed [DW-1:0]                 diff;
    logic [DW-2:0]                        diff_pos;
    logic [PW-1:0]                        prod_reg;
    logic [QW-1:0]                        quot;
    logic [IDX_W-1:0]                     lim, coord_idx;
    logic [IDX_W-1:0]                     ix0_reg, ix1_reg, iy0_reg, iy1_reg;
    logic [IDX_W-1:0]                     i_reg, j_reg;
    logic [LIN_W-1:0]                     lin;
    logic [CELL_W-1:0]                    cur_cell, fill_addr;

    logic [FILL_W-1:0]                    fill_mem [CELLS];
    logic [CELLS-1:0]                     fill_valid_reg;
    logic [FILL_W-1:0]                    fill_q_reg;
    logic                                 fill_v_reg;
    logic [FILL_W-1:0]                    fill_eff;
    logic [CELL_W-1:0]                    cell_q_reg;
    logic                                 slot_full;

    logic [OBJ_W-1:0]                     member_mem [MEM_D];
    logic [BOX_W-1:0]                     box_mem [MAX_OBJECTS];

    logic [CELL_W-1:0]                    c_reg;
    logic [FILL_W-1:0]                    f_reg;
    logic [SLOT_W-1:0]                    p_reg, q_reg;
    logic [OBJ_W-1:0]                     ma_reg, mb_reg, lo_id, hi_id;
    logic [OBJ_W-1:0]                     a_reg, b_reg;
    logic                                 ne_reg;
    logic [BOX_W-1:0]                     ba_reg, bb_reg;
    logic signed [COORD_BITS-1:0]         ax0, ay0, ax1, ay1, cx0, cy0, cx1, cy1;
    logic                                 overlap;
    logic                                 q_end;

    logic [MAX_OBJECTS-1:0][MAX_OBJECTS-1:0] seen_reg;
    logic [OBJ_W-1:0]                     sa_reg, sb_reg, pa_reg, pb_reg;
    logic                                 pend_reg;
    logic                                 hit;
    logic                                 out_free;
    logic                                 emit_pair;

    always_comb
    begin
        if (div_reg == '0)
        begin
            div_eff = IDX_W'(1);
        end
        else if (32'(div_reg) > GRID_DIV)
        begin
            div_eff = IDX_W'(GRID_DIV);
        end
        else
        begin
            div_eff = IDX_W'(div_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            scale_x_reg  <= gbpc_pkg::SCALE_W'(65536);
            scale_y_reg  <= gbpc_pkg::SCALE_W'(65536);
            div_reg      <= gbpc_pkg::DIV_REG_W'(8);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                gbpc_pkg::REG_ORIGIN_X:  origin_x_reg <= cfg_data[gbpc_pkg::ORIGIN_W-1:0];
                gbpc_pkg::REG_ORIGIN_Y:  origin_y_reg <= cfg_data[gbpc_pkg::ORIGIN_W-1:0];
                gbpc_pkg::REG_SCALE_X:   scale_x_reg  <= cfg_data;
                gbpc_pkg::REG_SCALE_Y:   scale_y_reg  <= cfg_data;
                gbpc_pkg::REG_DIVISIONS: div_reg      <= cfg_data[gbpc_pkg::DIV_REG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (k_reg)
            2'd0:
            begin
                coord_sel = bx0_reg;
                org_sel   = origin_x_reg;
                scale_sel = scale_x_reg;
            end
            2'd1:
            begin
                coord_sel = bx1_reg;
                org_sel   = origin_x_reg;
                scale_sel = scale_x_reg;
            end
            2'd2:
            begin
                coord_sel = by0_reg;
                org_sel   = origin_y_reg;
                scale_sel = scale_y_reg;
            end
            default:
            begin
                coord_sel = by1_reg;
                org_sel   = origin_y_reg;
                scale_sel = scale_y_reg;
            end
        endcase
    end

    assign diff      = DW'(coord_sel) - DW'(org_sel);
    assign diff_pos  = (diff[DW-1] || diff == '0) ? '0 : diff[DW-2:0];
    assign quot      = prod_reg[PW-1:gbpc_pkg::FRAC_BITS];
    assign lim       = div_eff - IDX_W'(1);
    assign coord_idx = (quot > QW'(lim)) ? lim : quot[IDX_W-1:0];
    assign lin       = LIN_W'(i_reg) + LIN_W'(j_reg) * LIN_W'(div_eff);
    assign cur_cell  = lin[CELL_W-1:0];
    assign fill_addr = cmd.sfill_rd ? c_reg : cur_cell;
    assign fill_eff  = fill_v_reg ? fill_q_reg : '0;
    assign slot_full = (32'(fill_eff) >= CELL_SLOTS);
    assign q_end     = (FILL_W'(q_reg) + FILL_W'(1) == f_reg);
    assign lo_id     = (ma_reg < mb_reg) ? ma_reg : mb_reg;
    assign hi_id     = (ma_reg < mb_reg) ? mb_reg : ma_reg;

    assign ax0 = ba_reg[4*COORD_BITS-1:3*COORD_BITS];
    assign ay0 = ba_reg[3*COORD_BITS-1:2*COORD_BITS];
    assign ax1 = ba_reg[2*COORD_BITS-1:COORD_BITS];
    assign ay1 = ba_reg[COORD_BITS-1:0];
    assign cx0 = bb_reg[4*COORD_BITS-1:3*COORD_BITS];
    assign cy0 = bb_reg[3*COORD_BITS-1:2*COORD_BITS];
    assign cx1 = bb_reg[2*COORD_BITS-1:COORD_BITS];
    assign cy1 = bb_reg[COORD_BITS-1:0];
    assign overlap = (ax0 <= cx1) && (cx0 <= ax1) && (ay0 <= cy1) && (cy0 <= ay1);

    assign hit       = seen_reg[sa_reg][sb_reg];
    assign out_free  = !out_valid || out_ready;
    assign emit_pair = cmd.scan_step && hit && pend_reg;

    always_comb
    begin
        stat            = '0;
        stat.cmd        = cmd_reg;
        stat.store_full = (32'(count_reg) >= MAX_OBJECTS);
        stat.map_last   = (k_reg == 2'd3);
        stat.span_empty = (ix0_reg > ix1_reg) || (iy0_reg > iy1_reg);
        stat.span_last  = (i_reg == ix1_reg) && (j_reg == iy1_reg);
        stat.fill_ge2   = (fill_eff >= FILL_W'(2));
        stat.pair_last  = q_end && (FILL_W'(p_reg) + FILL_W'(2) == f_reg);
        stat.cell_last  = (c_reg == CELL_W'(CELLS - 1));
        stat.scan_last  = (32'(sa_reg) == MAX_OBJECTS - 1) && (32'(sb_reg) == MAX_OBJECTS - 1);
        stat.scan_hold  = hit && pend_reg && !out_free;
        stat.out_free   = out_free;
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            bx0_reg <= box_min_x;
            by0_reg <= box_min_y;
            bx1_reg <= box_max_x;
            by1_reg <= box_max_y;
        end
        if (cmd.store_box)
        begin
            box_mem[count_reg[OBJ_W-1:0]] <= {bx0_reg, by0_reg, bx1_reg, by1_reg};
            id_reg <= count_reg[OBJ_W-1:0];
        end
        if (cmd.mul)
        begin
            prod_reg <= PW'(diff_pos) * PW'(scale_sel);
        end
        if (cmd.clamp)
        begin
            case (k_reg)
                2'd0:    ix0_reg <= coord_idx;
                2'd1:    ix1_reg <= coord_idx;
                2'd2:    iy0_reg <= coord_idx;
                default: iy1_reg <= coord_idx;
            endcase
        end
        if (cmd.cell_init)
        begin
            i_reg <= ix0_reg;
            j_reg <= iy0_reg;
        end
        if (cmd.fill_upd)
        begin
            if (j_reg == iy1_reg)
            begin
                j_reg <= iy0_reg;
                i_reg <= i_reg + IDX_W'(1);
            end
            else
            begin
                j_reg <= j_reg + IDX_W'(1);
            end
            if (!slot_full)
            begin
                member_mem[{cell_q_reg, fill_eff[SLOT_W-1:0]}] <= id_reg;
                fill_mem[cell_q_reg] <= fill_eff + FILL_W'(1);
            end
        end
        if (cmd.fill_rd || cmd.sfill_rd)
        begin
            fill_q_reg <= fill_mem[fill_addr];
            cell_q_reg <= fill_addr;
        end
        if (cmd.pair_init)
        begin
            f_reg <= fill_eff;
            p_reg <= '0;
            q_reg <= SLOT_W'(1);
        end
        if (cmd.mem_rd)
        begin
            ma_reg <= member_mem[{cell_q_reg, p_reg}];
            mb_reg <= member_mem[{cell_q_reg, q_reg}];
        end
        if (cmd.box_rd)
        begin
            ba_reg <= box_mem[lo_id];
            bb_reg <= box_mem[hi_id];
            a_reg  <= lo_id;
            b_reg  <= hi_id;
            ne_reg <= (ma_reg != mb_reg);
        end
        if (cmd.test)
        begin
            if (q_end)
            begin
                p_reg <= p_reg + SLOT_W'(1);
                q_reg <= p_reg + SLOT_W'(2);
            end
            else
            begin
                q_reg <= q_reg + SLOT_W'(1);
            end
        end
        if (cmd.scan_step && hit)
        begin
            pa_reg <= sa_reg;
            pb_reg <= sb_reg;
        end
        if (cmd.emit_simple)
        begin
            pair_valid    <= 1'b0;
            first_object  <= '0;
            second_object <= '0;
            last          <= 1'b1;
            status        <= st_reg;
        end
        else if (emit_pair)
        begin
            pair_valid    <= 1'b1;
            first_object  <= gbpc_pkg::OBJ_PORT_W'(pa_reg);
            second_object <= gbpc_pkg::OBJ_PORT_W'(pb_reg);
            last          <= 1'b0;
            status        <= gbpc_pkg::STATUS_OK;
        end
        else if (cmd.emit_final)
        begin
            pair_valid    <= pend_reg;
            first_object  <= pend_reg ? gbpc_pkg::OBJ_PORT_W'(pa_reg) : '0;
            second_object <= pend_reg ? gbpc_pkg::OBJ_PORT_W'(pb_reg) : '0;
            last          <= 1'b1;
            status        <= gbpc_pkg::STATUS_OK;
        end
    end

    // Control registers with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg        <= gbpc_pkg::CMD_CLEAR;
            count_reg      <= '0;
            st_reg         <= gbpc_pkg::STATUS_OK;
            k_reg          <= '0;
            fill_valid_reg <= '0;
            fill_v_reg     <= 1'b0;
            c_reg          <= '0;
            seen_reg       <= '0;
            sa_reg         <= '0;
            sb_reg         <= '0;
            pend_reg       <= 1'b0;
            out_valid      <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                cmd_reg <= command;
                st_reg  <= gbpc_pkg::STATUS_OK;
            end
            if (cmd.clear_all)
            begin
                count_reg      <= '0;
                fill_valid_reg <= '0;
            end
            if (cmd.set_full)
            begin
                st_reg <= gbpc_pkg::STATUS_STORE_FULL;
            end
            if (cmd.store_box)
            begin
                count_reg <= count_reg + CNT_W'(1);
                k_reg     <= '0;
            end
            if (cmd.clamp)
            begin
                k_reg <= k_reg + 2'd1;
            end
            if (cmd.fill_rd || cmd.sfill_rd)
            begin
                fill_v_reg <= fill_valid_reg[fill_addr];
            end
            if (cmd.fill_upd)
            begin
                if (slot_full)
                begin
                    st_reg <= gbpc_pkg::STATUS_CELL_FULL;
                end
                else
                begin
                    fill_valid_reg[cell_q_reg] <= 1'b1;
                end
            end
            if (cmd.solve_init)
            begin
                c_reg    <= '0;
                seen_reg <= '0;
            end
            if (cmd.cell_next)
            begin
                c_reg <= c_reg + CELL_W'(1);
            end
            if (cmd.test && ne_reg && overlap)
            begin
                seen_reg[a_reg][b_reg] <= 1'b1;
            end
            if (cmd.scan_init)
            begin
                sa_reg   <= '0;
                sb_reg   <= '0;
                pend_reg <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                if (hit)
                begin
                    pend_reg <= 1'b1;
                end
                if (32'(sb_reg) == MAX_OBJECTS - 1)
                begin
                    sb_reg <= '0;
                    sa_reg <= sa_reg + OBJ_W'(1);
                end
                else
                begin
                    sb_reg <= sb_reg + OBJ_W'(1);
                end
            end
            if (cmd.emit_simple || emit_pair || cmd.emit_final)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/grid_broad_phase_collision_unit.sv
// Top level of the grid broad-phase collision unit.
// The input channel (in_valid/in_ready) carries one command per transaction:
// clear, add box or solve. The output channel (out_valid/out_ready) returns
// one result per clear, add or unused command, and one result per colliding
// pair for solve, or a single empty result when no pair collides; last marks
// the final result of each command. Configuration writes go through
// cfg_write_en, cfg_index and cfg_data and take effect at once.
// One command is processed at a time, and in_ready stays low until it is done.
// Clear, unused and store-full add commands go from decode to the response.
// An add maps the four corners one after another through the shared Q8.16
// multiplier, then reads and updates the fill table for each cell the box spans.
// Solve reads the fill of each cell, tests each slot pair in a cell that holds
// two or more entries, and then scans the MAX_OBJECTS squared pair table
// entry by entry during emission.
// Reset empties the object store and every cell and restores the default
// configuration. A result waits in the output register while the receiver
// stalls; the next command is still accepted, and emission pauses until the
// register is free.
`default_nettype none

module grid_broad_phase_collision_unit
#(
    parameter int MAX_OBJECTS = 8,
    parameter int GRID_DIV    = 8,
    parameter int CELL_SLOTS  = 8,
    parameter int COORD_BITS  = 16
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write_en,
    input  wire logic [gbpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gbpc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [gbpc_pkg::CMD_W-1:0]         command,
    input  wire logic [COORD_BITS-1:0]              box_min_x,
    input  wire logic [COORD_BITS-1:0]              box_min_y,
    input  wire logic [COORD_BITS-1:0]              box_max_x,
    input  wire logic [COORD_BITS-1:0]              box_max_y,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    pair_valid,
    output logic [gbpc_pkg::OBJ_PORT_W-1:0]         first_object,
    output logic [gbpc_pkg::OBJ_PORT_W-1:0]         second_object,
    output logic                                    last,
    output logic [gbpc_pkg::STATUS_W-1:0]           status
);

    gbpc_pkg::ctrl_cmd_t cmd;
    gbpc_pkg::dp_stat_t  stat;

    gbpc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gbpc_dpath
    #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .GRID_DIV    (GRID_DIV),
        .CELL_SLOTS  (CELL_SLOTS),
        .COORD_BITS  (COORD_BITS)
    )
    u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (command),
        .box_min_x     (box_min_x),
        .box_min_y     (box_min_y),
        .box_max_x     (box_max_x),
        .box_max_y     (box_max_y),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pair_valid    (pair_valid),
        .first_object  (first_object),
        .second_object (second_object),
        .last          (last),
        .status        (status)
    );

endmodule

`default_nettype wire

### rtl/gbpc_checker.sv
// Port-level checker for the collision unit, bound to the top level.
`default_nettype none

module gbpc_checker
(
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               out_valid,
    input wire logic                               out_ready,
    input wire logic                               pair_valid,
    input wire logic [gbpc_pkg::OBJ_PORT_W-1:0]    first_object,
    input wire logic [gbpc_pkg::OBJ_PORT_W-1:0]    second_object,
    input wire logic                               last,
    input wire logic [gbpc_pkg::STATUS_W-1:0]      status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(first_object)
            && $stable(second_object) && $stable(last))
        else $error("Result changed while stalled.");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pair_valid |-> first_object < second_object)
        else $error("Pair not in ascending order.");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pair_valid |-> last && first_object == '0 && second_object == '0)
        else $error("Empty result is not final.");

    a_pair_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pair_valid |-> status == gbpc_pkg::STATUS_OK)
        else $error("Pair result carries an error status.");

endmodule

bind grid_broad_phase_collision_unit gbpc_checker u_gbpc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pair_valid    (pair_valid),
    .first_object  (first_object),
    .second_object (second_object),
    .last          (last),
    .status        (status)
);

`default_nettype wire

### test/grid_broad_phase_collision_unit_test.sv
// Self-checking testbench for the grid broad-phase collision unit.
`default_nettype none

class collision_scoreboard;
    typedef struct packed {
        logic       pair_valid;
        logic [2:0] first_object;
        logic [2:0] second_object;
        logic       last;
        logic [1:0] status;
    } result_t;

    logic signed [16:0] org_x, org_y;
    logic [23:0] scl_x, scl_y;
    logic [3:0] div_reg;
    logic signed [16:0] bx0[8], by0[8], bx1[8], by1[8];
    int obj_count;
    logic [2:0] members[64][8];
    int fill[64];
    result_t pending[$];
    int errors;
    int pairs_seen;
    int full_seen;

    function new();
        org_x = 0;
        org_y = 0;
        scl_x = 24'd65536;
        scl_y = 24'd65536;
        div_reg = 4'd8;
        obj_count = 0;
        errors = 0;
        pairs_seen = 0;
        full_seen = 0;
        foreach (fill[i]) fill[i] = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
        case (idx)
            gbpc_pkg::REG_ORIGIN_X:  org_x = $signed(val[15:0]);
            gbpc_pkg::REG_ORIGIN_Y:  org_y = $signed(val[15:0]);
            gbpc_pkg::REG_SCALE_X:   scl_x = val;
            gbpc_pkg::REG_SCALE_Y:   scl_y = val;
            gbpc_pkg::REG_DIVISIONS: div_reg = val[3:0];
            default: ;
        endcase
    endfunction

    function int cell_index(logic signed [16:0] c, logic signed [16:0] o,
                            logic [23:0] s, int dv);
        logic signed [17:0] d;
        logic [41:0] q;
        d = c - o;
        if (d <= 0) return 0;
        q = (42'(d) * 42'(s)) >> 16;
        if (q > 42'(dv - 1)) return dv - 1;
        return int'(q);
    endfunction

    function void push(logic v, int a, int b, logic l, logic [1:0] st);
        result_t r;
        r.pair_valid = v;
        r.first_object = a[2:0];
        r.second_object = b[2:0];
        r.last = l;
        r.status = st;
        pending = {pending, r};
    endfunction

    function void note_command(logic [1:0] cmd, logic [15:0] x0, logic [15:0] y0,
                               logic [15:0] x1, logic [15:0] y1);
        int dv, ix0, ix1, iy0, iy1, c, n;
        logic [1:0] st;
        bit seen[8][8];
        if (cmd == gbpc_pkg::CMD_ADD) begin
            if (obj_count >= 8) begin
                push(0, 0, 0, 1, gbpc_pkg::STATUS_STORE_FULL);
                full_seen++;
                return;
            end
            dv = (div_reg == 0) ? 1 : (div_reg > 8) ? 8 : int'(div_reg);
            bx0[obj_count] = $signed(x0);
            by0[obj_count] = $signed(y0);
            bx1[obj_count] = $signed(x1);
            by1[obj_count] = $signed(y1);
            ix0 = cell_index($signed(x0), org_x, scl_x, dv);
            ix1 = cell_index($signed(x1), org_x, scl_x, dv);
            iy0 = cell_index($signed(y0), org_y, scl_y, dv);
            iy1 = cell_index($signed(y1), org_y, scl_y, dv);
            st = gbpc_pkg::STATUS_OK;
            for (int i = ix0; i <= ix1; i++) begin
                for (int j = iy0; j <= iy1; j++) begin
                    c = i + j * dv;
                    if (c < 64) begin
                        if (fill[c] >= 8) begin
                            st = gbpc_pkg::STATUS_CELL_FULL;
                        end else begin
                            members[c][fill[c]] = obj_count[2:0];
                            fill[c]++;
                        end
                    end
                end
            end
            obj_count++;
            if (st == gbpc_pkg::STATUS_CELL_FULL) full_seen++;
            push(0, 0, 0, 1, st);
        end else if (cmd == gbpc_pkg::CMD_SOLVE) begin
            int a, b, t;
            n = 0;
            foreach (seen[i, j]) seen[i][j] = 0;
            for (int ci = 0; ci < 64; ci++) begin
                for (int p = 0; p < fill[ci]; p++) begin
                    for (int q = p + 1; q < fill[ci]; q++) begin
                        a = members[ci][p];
                        b = members[ci][q];
                        if (a != b) begin
                            if (a > b) begin
                                t = a;
                                a = b;
                                b = t;
                            end
                            if (bx0[a] <= bx1[b] && bx0[b] <= bx1[a] &&
                                by0[a] <= by1[b] && by0[b] <= by1[a])
                                seen[a][b] = 1;
                        end
                    end
                end
            end
            for (int i = 0; i < 8; i++) begin
                for (int j = i + 1; j < 8; j++) begin
                    if (seen[i][j]) begin
                        push(1, i, j, 0, gbpc_pkg::STATUS_OK);
                        n++;
                    end
                end
            end
            pairs_seen += n;
            if (n == 0) push(0, 0, 0, 1, gbpc_pkg::STATUS_OK);
            else pending[pending.size() - 1].last = 1;
        end else begin
            if (cmd == gbpc_pkg::CMD_CLEAR) begin
                obj_count = 0;
                foreach (fill[i]) fill[i] = 0;
            end
            push(0, 0, 0, 1, gbpc_pkg::STATUS_OK);
        end
    endfunction

    function void report(string field, int e, int a);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field, e, a);
        errors++;
    endfunction

    function void check_result(result_t got);
        result_t exp_r;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result, actual %p", $realtime, got);
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (got.pair_valid !== exp_r.pair_valid)
            report("pair_valid", exp_r.pair_valid, got.pair_valid);
        if (got.first_object !== exp_r.first_object)
            report("first_object", exp_r.first_object, got.first_object);
        if (got.second_object !== exp_r.second_object)
            report("second_object", exp_r.second_object, got.second_object);
        if (got.last !== exp_r.last)
            report("last", exp_r.last, got.last);
        if (got.status !== exp_r.status)
            report("status", exp_r.status, got.status);
    endfunction
endclass

module grid_broad_phase_collision_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_write_en = 0;
    logic [2:0] cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_ready;
    logic [1:0] command = '0;
    logic [15:0] box_min_x = '0, box_min_y = '0, box_max_x = '0, box_max_y = '0;
    logic out_valid;
    logic out_ready = 0;
    logic pair_valid, last;
    logic [2:0] first_object, second_object;
    logic [1:0] status;

    collision_scoreboard board = new();
    int idle_cycles = 0;
    int sent = 0;
    bit sending_done = 0;

    grid_broad_phase_collision_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_write_en(cfg_write_en), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .box_min_x(box_min_x), .box_min_y(box_min_y),
        .box_max_x(box_max_x), .box_max_y(box_max_y), .out_valid(out_valid),
        .out_ready(out_ready), .pair_valid(pair_valid), .first_object(first_object),
        .second_object(second_object), .last(last), .status(status)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result({pair_valid, first_object, second_object, last, status});
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        int gap;
        gap = $urandom_range(0, 19);
        if (sending_done && gap > 14) gap = 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap == 0)
        begin
            out_ready <= 1;
        end
        else
        begin
            out_ready <= 0;
            repeat (gap) @(posedge clk);
            out_ready <= 1;
        end
        while (!(out_valid && out_ready && rst_n)) @(posedge clk);
    end

    task automatic send(logic [1:0] cmd, logic [15:0] x0, logic [15:0] y0,
                        logic [15:0] x1, logic [15:0] y1, bit no_gaps);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        command <= cmd;
        box_min_x <= x0;
        box_min_y <= y0;
        box_max_x <= x1;
        box_max_y <= y1;
        do @(posedge clk); while (!in_ready);
        board.note_command(cmd, x0, y0, x1, y1);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        cfg_write_en <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        board.write_reg(idx, val);
        cfg_write_en <= 0;
        @(posedge clk);
    endtask

    task automatic add_box(logic [15:0] x0, logic [15:0] y0, logic [15:0] x1,
                           logic [15:0] y1);
        send(gbpc_pkg::CMD_ADD, x0, y0, x1, y1, 0);
    endtask

    task automatic simple(logic [1:0] cmd);
        send(cmd, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 0);
    endtask

    task automatic add_random(int span);
        logic [15:0] x, y;
        x = 16'($urandom_range(0, 70));
        y = 16'($urandom_range(0, 70));
        if ($urandom_range(0, 9) == 0)
            add_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        else
            add_box(x, y, x + 16'($urandom_range(0, span)), y + 16'($urandom_range(0, span)));
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        simple(gbpc_pkg::CMD_SOLVE);
        add_box(16'd0, 16'd0, 16'd2, 16'd2);
        add_box(16'd2, 16'd2, 16'd3, 16'd3);
        add_box(16'd5, 16'd5, 16'd3, 16'd3);
        add_box(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        add_box(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        add_box(16'd4, 16'd0, 16'd4, 16'd7);
        add_box(16'd0, 16'd4, 16'd7, 16'd4);
        add_box(16'd1, 16'd1, 16'd1, 16'd1);
        add_box(16'd1, 16'd1, 16'd1, 16'd1);
        simple(gbpc_pkg::CMD_SOLVE);
        simple(gbpc_pkg::CMD_SOLVE);
        simple(gbpc_pkg::CMD_NONE);
        simple(gbpc_pkg::CMD_CLEAR);
        for (int i = 0; i < 8; i++)
            add_box(16'd0, 16'd0, 16'd7, 16'($signed(i - 1)));
        simple(gbpc_pkg::CMD_SOLVE);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin
                    write_reg(gbpc_pkg::REG_ORIGIN_X, 24'h008000);
                    write_reg(gbpc_pkg::REG_ORIGIN_Y, 24'h007fff);
                    write_reg(gbpc_pkg::REG_DIVISIONS, 24'd0);
                end
                1: begin
                    write_reg(gbpc_pkg::REG_ORIGIN_X, 24'hfffff6);
                    write_reg(gbpc_pkg::REG_ORIGIN_Y, 24'd5);
                    write_reg(gbpc_pkg::REG_SCALE_X, 24'hffffff);
                    write_reg(gbpc_pkg::REG_SCALE_Y, 24'd0);
                    write_reg(gbpc_pkg::REG_DIVISIONS, 24'd15);
                end
                2: begin
                    write_reg(gbpc_pkg::REG_ORIGIN_X, 24'd0);
                    write_reg(gbpc_pkg::REG_ORIGIN_Y, 24'd0);
                    write_reg(gbpc_pkg::REG_SCALE_X, 24'd6554);
                    write_reg(gbpc_pkg::REG_SCALE_Y, 24'd8192);
                    write_reg(gbpc_pkg::REG_DIVISIONS, 24'd8);
                end
                3: write_reg(gbpc_pkg::REG_DIVISIONS, 24'd1);
                4: begin
                    write_reg(gbpc_pkg::REG_SCALE_X, 24'(($urandom_range(1, 64)) << 12));
                    write_reg(gbpc_pkg::REG_SCALE_Y, 24'(($urandom_range(1, 64)) << 12));
                    write_reg(gbpc_pkg::REG_DIVISIONS, 24'($urandom_range(2, 8)));
                    write_reg(gbpc_pkg::REG_ORIGIN_X, 24'($urandom_range(0, 20)));
                end
                default: begin
                    write_reg(gbpc_pkg::REG_SCALE_X, 24'd8192);
                    write_reg(gbpc_pkg::REG_SCALE_Y, 24'd8192);
                    write_reg(gbpc_pkg::REG_ORIGIN_X, 24'd0);
                    write_reg(gbpc_pkg::REG_DIVISIONS, 24'($urandom_range(3, 8)));
                end
            endcase
            for (int r = 0; r < 3; r++)
            begin
                int n;
                simple(gbpc_pkg::CMD_CLEAR);
                n = $urandom_range(2, 9);
                for (int k = 0; k < n; k++) add_random((ph == 7) ? 60 : 12);
                simple(gbpc_pkg::CMD_SOLVE);
                if ($urandom_range(0, 5) == 0) simple(gbpc_pkg::CMD_NONE);
            end
            drain();
        end

        sending_done = 1;
        drain();
        $display("Sent %0d commands; %0d colliding pairs and %0d full-store or full-cell adds.",
                 sent, board.pairs_seen, board.full_seen);
        $display("Covered clear, add, solve and unused commands over eight register settings.");
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

`default_nettype wire
